// File: hw/rtl/evm_word_alu_assert.svh
// Assertion macros used by the evm_word_alu port-level checker.
`ifndef EVM_WORD_ALU_ASSERT_SVH
`define EVM_WORD_ALU_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define EWA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Consequence that must hold in the clock cycle after the antecedent.
`define EWA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ewa_pkg.sv
// Package for the EVM word ALU: widths, opcodes, datapath commands and types.
package ewa_pkg;

   localparam int LIMB_BITS = 64;
   localparam int NUM_LIMBS = 4;
   localparam int WORD_BITS = LIMB_BITS * NUM_LIMBS;
   localparam int IDX_BITS  = 2;
   localparam int CNT_BITS  = $clog2(2 * WORD_BITS);
   localparam int BIT_BITS  = $clog2(WORD_BITS);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EXEC = 1'b1;

   localparam logic [7:0] OP_ADD     = 8'h01;
   localparam logic [7:0] OP_MUL     = 8'h02;
   localparam logic [7:0] OP_SUB     = 8'h03;
   localparam logic [7:0] OP_DIV     = 8'h04;
   localparam logic [7:0] OP_SDIV    = 8'h05;
   localparam logic [7:0] OP_MOD     = 8'h06;
   localparam logic [7:0] OP_SMOD    = 8'h07;
   localparam logic [7:0] OP_ADDMOD  = 8'h08;
   localparam logic [7:0] OP_MULMOD  = 8'h09;
   localparam logic [7:0] OP_EXP     = 8'h0a;
   localparam logic [7:0] OP_SIGNEXT = 8'h0b;
   localparam logic [7:0] OP_LT      = 8'h10;
   localparam logic [7:0] OP_GT      = 8'h11;
   localparam logic [7:0] OP_SLT     = 8'h12;
   localparam logic [7:0] OP_SGT     = 8'h13;
   localparam logic [7:0] OP_EQ      = 8'h14;
   localparam logic [7:0] OP_ISZERO  = 8'h15;
   localparam logic [7:0] OP_AND     = 8'h16;
   localparam logic [7:0] OP_OR      = 8'h17;
   localparam logic [7:0] OP_XOR     = 8'h18;
   localparam logic [7:0] OP_NOT     = 8'h19;
   localparam logic [7:0] OP_BYTE    = 8'h1a;
   localparam logic [7:0] OP_SHL     = 8'h1b;
   localparam logic [7:0] OP_SHR     = 8'h1c;
   localparam logic [7:0] OP_SAR     = 8'h1d;

   localparam logic [3:0] DP_IDLE        = 4'd0;
   localparam logic [3:0] DP_LOAD        = 4'd1;
   localparam logic [3:0] DP_SIMPLE      = 4'd2;
   localparam logic [3:0] DP_CLEAR       = 4'd3;
   localparam logic [3:0] DP_DIV_INIT_U  = 4'd4;
   localparam logic [3:0] DP_DIV_INIT_S  = 4'd5;
   localparam logic [3:0] DP_ADDMOD_INIT = 4'd6;
   localparam logic [3:0] DP_MOD_INIT    = 4'd7;
   localparam logic [3:0] DP_DIV_STEP    = 4'd8;
   localparam logic [3:0] DP_MUL_INIT    = 4'd9;
   localparam logic [3:0] DP_MUL_STEP    = 4'd10;
   localparam logic [3:0] DP_FINISH      = 4'd11;
   localparam logic [3:0] DP_EXP_INIT    = 4'd12;
   localparam logic [3:0] DP_EXP_TAKE    = 4'd13;

   localparam logic [1:0] SRC_AB = 2'd0;
   localparam logic [1:0] SRC_SQ = 2'd1;
   localparam logic [1:0] SRC_RA = 2'd2;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic [3:0]          op;
      logic [1:0]          src;
      logic [7:0]          opcode;
      logic [BIT_BITS-1:0] bit_idx;
      logic [IDX_BITS-1:0] emit_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic b_zero;
      logic c_zero;
      logic b_bit;
   } dp_status_type;

endpackage

// File: hw/rtl/ewa_ifs.sv
// Request and response channel interfaces of the EVM word ALU.
interface ewa_req_if import ewa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 command;
   logic [7:0]           opcode;
   logic [IDX_BITS-1:0]  limb_index;
   logic [LIMB_BITS-1:0] a_limb;
   logic [LIMB_BITS-1:0] b_limb;
   logic [LIMB_BITS-1:0] c_limb;

   modport source (output valid, command, opcode, limb_index, a_limb, b_limb, c_limb,
                   input ready);
   modport sink (input valid, command, opcode, limb_index, a_limb, b_limb, c_limb,
                 output ready);
endinterface

interface ewa_rsp_if import ewa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [LIMB_BITS-1:0] result_limb;
   logic [IDX_BITS-1:0]  result_index;
   logic                 supported;
   logic                 last;

   modport source (output valid, result_limb, result_index, supported, last, input ready);
   modport sink (input valid, result_limb, result_index, supported, last, output ready);
endinterface

// File: hw/rtl/ewa_datapath.sv
// Datapath of the EVM word ALU: operand words, shift-add multiplier, restoring divider.
module ewa_datapath import ewa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   input  logic [IDX_BITS-1:0]  load_idx,
   input  logic [LIMB_BITS-1:0] a_limb,
   input  logic [LIMB_BITS-1:0] b_limb,
   input  logic [LIMB_BITS-1:0] c_limb,
   output dp_status_type        status,
   output logic [LIMB_BITS-1:0] limb_out
);

   localparam int MSB = WORD_BITS - 1;

   word_type a_ff, b_ff, c_ff, res_ff;
   word_type x_ff, d_ff, rem_ff, hi_ff, lo_ff;

   logic [WORD_BITS:0] sum_w;
   logic               a_lt_31;
   word_type           sx_mask;
   logic               sx_bit;
   word_type           simple;
   word_type           abs_a, abs_b;
   word_type           neg_in, neg_out;
   logic [WORD_BITS:0] mul_sum;
   logic [WORD_BITS:0] rr, rdiff;
   logic               ge;

   always_comb begin
      sum_w   = {1'b0, a_ff} + {1'b0, b_ff};
      a_lt_31 = (a_ff[MSB:5] == '0) && (a_ff[4:0] != 5'd31);
      sx_mask = ~({WORD_BITS{1'b1}} << ({3'b000, a_ff[4:0], 3'b000} + 11'd8));
      sx_bit  = b_ff[{a_ff[4:0], 3'b111}];
      simple  = '0;
      case (cmd.opcode)
         OP_ADD:     simple = sum_w[MSB:0];
         OP_SUB:     simple = a_ff - b_ff;
         OP_SIGNEXT: simple = a_lt_31 ? ((b_ff & sx_mask) | ({WORD_BITS{sx_bit}} & ~sx_mask))
                                      : b_ff;
         OP_LT:      simple = word_type'(a_ff < b_ff);
         OP_GT:      simple = word_type'(a_ff > b_ff);
         OP_SLT:     simple = word_type'($signed(a_ff) < $signed(b_ff));
         OP_SGT:     simple = word_type'($signed(a_ff) > $signed(b_ff));
         OP_EQ:      simple = word_type'(a_ff == b_ff);
         OP_ISZERO:  simple = word_type'(a_ff == '0);
         OP_AND:     simple = a_ff & b_ff;
         OP_OR:      simple = a_ff | b_ff;
         OP_XOR:     simple = a_ff ^ b_ff;
         OP_NOT:     simple = ~a_ff;
         OP_BYTE: begin
            // Byte zero is the most significant one, so the shift is 31 - a bytes.
            if (a_ff[MSB:5] == '0)
               simple = word_type'(b_ff[{~a_ff[4:0], 3'b000} +: 8]);
         end
         OP_SHL: begin
            if (a_ff[MSB:8] == '0)
               simple = b_ff << a_ff[7:0];
         end
         OP_SHR: begin
            if (a_ff[MSB:8] == '0)
               simple = b_ff >> a_ff[7:0];
         end
         OP_SAR: simple = (a_ff[MSB:8] == '0) ? word_type'($signed(b_ff) >>> a_ff[7:0])
                                               : {WORD_BITS{b_ff[MSB]}};
         default: simple = '0;
      endcase
   end

   assign abs_a   = a_ff[MSB] ? ('0 - a_ff) : a_ff;
   assign abs_b   = b_ff[MSB] ? ('0 - b_ff) : b_ff;
   assign neg_in  = (cmd.opcode == OP_SDIV) ? lo_ff : rem_ff;
   assign neg_out = '0 - neg_in;

   // One multiplier bit per cycle, taken from the low end of lo_ff.
   assign mul_sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, x_ff} : '0);

   // One dividend bit per cycle, taken from the top of hi_ff.
   assign rr    = {rem_ff, hi_ff[MSB]};
   assign rdiff = rr - {1'b0, d_ff};
   assign ge    = rr >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff   <= '0;
         b_ff   <= '0;
         c_ff   <= '0;
         res_ff <= '0;
      end else begin
         case (cmd.op)
            DP_LOAD: begin
               a_ff[load_idx*LIMB_BITS +: LIMB_BITS] <= a_limb;
               b_ff[load_idx*LIMB_BITS +: LIMB_BITS] <= b_limb;
               c_ff[load_idx*LIMB_BITS +: LIMB_BITS] <= c_limb;
            end
            DP_SIMPLE: res_ff <= simple;
            DP_CLEAR:  res_ff <= '0;
            DP_DIV_INIT_U: begin
               hi_ff  <= a_ff;
               lo_ff  <= '0;
               d_ff   <= b_ff;
               rem_ff <= '0;
            end
            DP_DIV_INIT_S: begin
               hi_ff  <= abs_a;
               lo_ff  <= '0;
               d_ff   <= abs_b;
               rem_ff <= '0;
            end
            DP_ADDMOD_INIT: begin
               hi_ff  <= word_type'(sum_w[WORD_BITS]);
               lo_ff  <= sum_w[MSB:0];
               d_ff   <= c_ff;
               rem_ff <= '0;
            end
            DP_MOD_INIT: begin
               d_ff   <= c_ff;
               rem_ff <= '0;
            end
            DP_DIV_STEP: begin
               rem_ff <= ge ? rdiff[MSB:0] : rr[MSB:0];
               hi_ff  <= {hi_ff[MSB-1:0], lo_ff[MSB]};
               lo_ff  <= {lo_ff[MSB-1:0], ge};
            end
            DP_MUL_INIT: begin
               hi_ff <= '0;
               case (cmd.src)
                  SRC_AB: begin
                     x_ff  <= a_ff;
                     lo_ff <= b_ff;
                  end
                  SRC_SQ: begin
                     x_ff  <= res_ff;
                     lo_ff <= res_ff;
                  end
                  default: begin
                     x_ff  <= a_ff;
                     lo_ff <= res_ff;
                  end
               endcase
            end
            DP_MUL_STEP: begin
               hi_ff <= mul_sum[WORD_BITS:1];
               lo_ff <= {mul_sum[0], lo_ff[MSB:1]};
            end
            DP_FINISH: begin
               case (cmd.opcode)
                  OP_MUL, OP_DIV: res_ff <= lo_ff;
                  OP_SDIV:        res_ff <= (a_ff[MSB] ^ b_ff[MSB]) ? neg_out : lo_ff;
                  OP_SMOD:        res_ff <= a_ff[MSB] ? neg_out : rem_ff;
                  default:        res_ff <= rem_ff;
               endcase
            end
            DP_EXP_INIT: res_ff <= word_type'(1);
            DP_EXP_TAKE: res_ff <= lo_ff;
            default: ;
         endcase
      end
   end

   assign status.b_zero = (b_ff == '0);
   assign status.c_zero = (c_ff == '0);
   assign status.b_bit  = b_ff[cmd.bit_idx];
   assign limb_out      = res_ff[cmd.emit_idx*LIMB_BITS +: LIMB_BITS];

endmodule

// File: hw/rtl/ewa_ctrl.sv
// Sequencer of the EVM word ALU: decodes requests and steps the datapath.
module ewa_ctrl import ewa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [7:0]          req_opcode,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [IDX_BITS-1:0] rsp_index,
   output logic                rsp_supported,
   output logic                rsp_last,
   output dp_cmd_type          cmd,
   input  dp_status_type       status
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_MUL      = 4'd2;
   localparam logic [3:0] S_MOD_INIT = 4'd3;
   localparam logic [3:0] S_DIV      = 4'd4;
   localparam logic [3:0] S_FINISH   = 4'd5;
   localparam logic [3:0] S_EXP_SQ   = 4'd6;
   localparam logic [3:0] S_EXP_TAKE = 4'd7;
   localparam logic [3:0] S_EXP_MUL  = 4'd8;
   localparam logic [3:0] S_EMIT     = 4'd9;

   localparam logic [CNT_BITS-1:0] WORD_STEPS   = CNT_BITS'(WORD_BITS - 1);
   localparam logic [CNT_BITS-1:0] DOUBLE_STEPS = CNT_BITS'(2 * WORD_BITS - 1);
   localparam logic [IDX_BITS-1:0] LAST_IDX     = IDX_BITS'(NUM_LIMBS - 1);

   logic [3:0]          state_ff, state_in;
   logic [7:0]          op_ff, op_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [CNT_BITS-1:0] limit_ff, limit_in;
   logic [BIT_BITS-1:0] bit_ff, bit_in;
   logic                phase_ff, phase_in;
   logic                sup_ff, sup_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      limit_in     = limit_ff;
      bit_in       = bit_ff;
      phase_in     = phase_ff;
      sup_in       = sup_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.opcode   = op_ff;
      cmd.bit_idx  = bit_ff;
      cmd.emit_idx = idx_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == CMD_LOAD) begin
                  cmd.op = DP_LOAD;
               end else begin
                  op_in    = req_opcode;
                  state_in = S_DISPATCH;
               end
            end
         end
         S_DISPATCH: begin
            sup_in   = 1'b1;
            cnt_in   = '0;
            idx_in   = '0;
            phase_in = 1'b0;
            state_in = S_EMIT;
            case (op_ff)
               OP_MUL, OP_MULMOD: begin
                  if (op_ff == OP_MULMOD && status.c_zero) begin
                     cmd.op = DP_CLEAR;
                  end else begin
                     cmd.op   = DP_MUL_INIT;
                     cmd.src  = SRC_AB;
                     state_in = S_MUL;
                  end
               end
               OP_DIV, OP_MOD: begin
                  if (status.b_zero) begin
                     cmd.op = DP_CLEAR;
                  end else begin
                     cmd.op   = DP_DIV_INIT_U;
                     limit_in = WORD_STEPS;
                     state_in = S_DIV;
                  end
               end
               OP_SDIV, OP_SMOD: begin
                  if (status.b_zero) begin
                     cmd.op = DP_CLEAR;
                  end else begin
                     cmd.op   = DP_DIV_INIT_S;
                     limit_in = WORD_STEPS;
                     state_in = S_DIV;
                  end
               end
               OP_ADDMOD: begin
                  if (status.c_zero) begin
                     cmd.op = DP_CLEAR;
                  end else begin
                     cmd.op   = DP_ADDMOD_INIT;
                     limit_in = DOUBLE_STEPS;
                     state_in = S_DIV;
                  end
               end
               OP_EXP: begin
                  cmd.op   = DP_EXP_INIT;
                  bit_in   = '1;
                  state_in = S_EXP_SQ;
               end
               default: begin
                  if (op_ff inside {OP_ADD, OP_SUB, OP_SIGNEXT, [OP_LT:OP_SAR]}) begin
                     cmd.op = DP_SIMPLE;
                  end else begin
                     cmd.op = DP_CLEAR;
                     sup_in = 1'b0;
                  end
               end
            endcase
         end
         S_MUL: begin
            cmd.op = DP_MUL_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == WORD_STEPS) begin
               if (op_ff == OP_MUL)
                  state_in = S_FINISH;
               else if (op_ff == OP_MULMOD)
                  state_in = S_MOD_INIT;
               else
                  state_in = S_EXP_TAKE;
            end
         end
         S_MOD_INIT: begin
            // The double-width product already sits in the shift register.
            cmd.op   = DP_MOD_INIT;
            cnt_in   = '0;
            limit_in = DOUBLE_STEPS;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = DP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == limit_ff)
               state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.op   = DP_FINISH;
            state_in = S_EMIT;
         end
         S_EXP_SQ: begin
            cmd.op   = DP_MUL_INIT;
            cmd.src  = SRC_SQ;
            cnt_in   = '0;
            phase_in = 1'b0;
            state_in = S_MUL;
         end
         S_EXP_TAKE: begin
            cmd.op = DP_EXP_TAKE;
            if (!phase_ff && status.b_bit) begin
               state_in = S_EXP_MUL;
            end else if (bit_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = S_EXP_SQ;
            end
         end
         S_EXP_MUL: begin
            cmd.op   = DP_MUL_INIT;
            cmd.src  = SRC_RA;
            cnt_in   = '0;
            phase_in = 1'b1;
            state_in = S_MUL;
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LAST_IDX)
                  state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= '0;
         cnt_ff   <= '0;
         limit_ff <= '0;
         bit_ff   <= '0;
         phase_ff <= 1'b0;
         sup_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
         limit_ff <= limit_in;
         bit_ff   <= bit_in;
         phase_ff <= phase_in;
         sup_ff   <= sup_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_index     = idx_ff;
   assign rsp_supported = sup_ff;
   assign rsp_last      = (idx_ff == LAST_IDX);

endmodule

// File: hw/rtl/evm_word_alu.sv
// Top level of the EVM word ALU: sequencer and datapath joined to the channels.
// Each request is handled to completion before the next is taken. A load request writes
// its limb of each operand word. An execute request returns four response limbs, least
// significant first, after a compute phase set by the opcode: the logic, compare, shift
// and add/sub group go through the combinational unit; MUL, DIV, SDIV, MOD and SMOD take
// one bit per cycle through the shared shift-add multiplier or restoring divider;
// ADDMOD and MULMOD end in a 512-bit reduction that takes one dividend bit per cycle;
// and EXP does a squaring for every exponent bit plus a multiply per set exponent bit,
// all on the shared multiplier. Zero divisors and unknown opcodes skip the iterative
// units.
module evm_word_alu import ewa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ewa_req_if.sink   req_ch,
   ewa_rsp_if.source rsp_ch
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   ewa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_command   (req_ch.command),
      .req_opcode    (req_ch.opcode),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_index     (rsp_ch.result_index),
      .rsp_supported (rsp_ch.supported),
      .rsp_last      (rsp_ch.last),
      .cmd           (dp_cmd),
      .status        (dp_status)
   );

   ewa_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (dp_cmd),
      .load_idx (req_ch.limb_index),
      .a_limb   (req_ch.a_limb),
      .b_limb   (req_ch.b_limb),
      .c_limb   (req_ch.c_limb),
      .status   (dp_status),
      .limb_out (rsp_ch.result_limb)
   );

endmodule

// File: hw/rtl/ewa_checker.sv
// Port-level checker for the EVM word ALU and its bind to the top level.
`include "evm_word_alu_assert.svh"

module ewa_checker import ewa_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [LIMB_BITS-1:0] result_limb,
   input logic [IDX_BITS-1:0]  result_index,
   input logic                 supported,
   input logic                 last
);

   `EWA_ASSERT(no_request_while_responding, rsp_valid |-> !req_ready, "request taken during response")
   `EWA_ASSERT(last_on_top_limb, rsp_valid |-> (last == (result_index == IDX_BITS'(NUM_LIMBS - 1))), "last flag misplaced")
   `EWA_ASSERT(unsupported_is_zero, (rsp_valid && !supported) |-> (result_limb == '0), "unsupported opcode gave nonzero limb")
   `EWA_ASSERT_NEXT(limbs_in_order, rsp_valid && rsp_ready && !last, rsp_valid && (result_index == IDX_BITS'($past(result_index) + 1'b1)), "response limbs out of order")

endmodule

bind evm_word_alu ewa_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .result_limb  (rsp_ch.result_limb),
   .result_index (rsp_ch.result_index),
   .supported    (rsp_ch.supported),
   .last         (rsp_ch.last)
);

// File: dv/ewa_checker.sv
// Checker for the EVM word ALU: predicts response limbs from observed requests and compares.
module ewa_scoreboard import ewa_pkg::*; (
   input  logic clock,
   input  logic reset,
   ewa_req_if   req_ch,
   ewa_rsp_if   rsp_ch,
   output int   fail_count,
   output int   pending
);

   typedef struct {
      logic [LIMB_BITS-1:0] limb;
      logic [IDX_BITS-1:0]  index;
      logic                 supported;
      logic                 last;
   } limb_rec_type;

   limb_rec_type expected_limbs[$];
   word_type     op_a, op_b, op_c;

   function automatic word_type abs_word(word_type x);
      return x[WORD_BITS-1] ? -x : x;
   endfunction

   function automatic word_type alu_eval(logic [7:0] opcode, word_type a, word_type b,
                                         word_type c, output logic sup);
      word_type     r, q;
      logic [511:0] wide;
      int           v;
      r = '0;
      sup = 1'b1;
      case (opcode)
         OP_ADD: r = a + b;
         OP_MUL: r = a * b;
         OP_SUB: r = a - b;
         OP_DIV: if (b != 0) r = a / b;
         OP_SDIV: if (b != 0) begin
            q = abs_word(a) / abs_word(b);
            r = (a[WORD_BITS-1] != b[WORD_BITS-1]) ? -q : q;
         end
         OP_MOD: if (b != 0) r = a % b;
         OP_SMOD: if (b != 0) begin
            q = abs_word(a) % abs_word(b);
            r = a[WORD_BITS-1] ? -q : q;
         end
         OP_ADDMOD: if (c != 0) begin
            wide = {256'd0, a} + {256'd0, b};
            wide = wide % {256'd0, c};
            r = wide[255:0];
         end
         OP_MULMOD: if (c != 0) begin
            wide = {256'd0, a} * {256'd0, b};
            wide = wide % {256'd0, c};
            r = wide[255:0];
         end
         OP_EXP: begin
            r = 1;
            for (int j = WORD_BITS - 1; j >= 0; j--) begin
               r = r * r;
               if (b[j]) r = r * a;
            end
         end
         OP_SIGNEXT: begin
            r = b;
            if (a < 31) begin
               v = int'(a) * 8 + 7;
               for (int i = v + 1; i < WORD_BITS; i++) r[i] = b[v];
            end
         end
         OP_LT: r = (a < b);
         OP_GT: r = (a > b);
         OP_SLT: r = ($signed(a) < $signed(b));
         OP_SGT: r = ($signed(a) > $signed(b));
         OP_EQ: r = (a == b);
         OP_ISZERO: r = (a == 0);
         OP_AND: r = a & b;
         OP_OR: r = a | b;
         OP_XOR: r = a ^ b;
         OP_NOT: r = ~a;
         OP_BYTE: if (a < 32) r = (b >> (8 * (31 - int'(a)))) & 256'hff;
         OP_SHL: if (a < 256) r = b << a[7:0];
         OP_SHR: if (a < 256) r = b >> a[7:0];
         // A shift of 255 already fills every bit with the sign.
         OP_SAR: r = $signed(b) >>> ((a < 256) ? a[7:0] : 8'd255);
         default: begin
            sup = 1'b0;
            r = '0;
         end
      endcase
      return r;
   endfunction

   assign pending = expected_limbs.size();

   always @(posedge clock) begin
      word_type     res;
      logic         sup;
      limb_rec_type rec;
      if (reset) begin
         op_a <= '0;
         op_b <= '0;
         op_c <= '0;
         fail_count <= 0;
         expected_limbs.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.command == CMD_LOAD) begin
               op_a[req_ch.limb_index*LIMB_BITS +: LIMB_BITS] <= req_ch.a_limb;
               op_b[req_ch.limb_index*LIMB_BITS +: LIMB_BITS] <= req_ch.b_limb;
               op_c[req_ch.limb_index*LIMB_BITS +: LIMB_BITS] <= req_ch.c_limb;
            end else begin
               res = alu_eval(req_ch.opcode, op_a, op_b, op_c, sup);
               for (int k = 0; k < NUM_LIMBS; k++) begin
                  rec.limb = res[k*LIMB_BITS +: LIMB_BITS];
                  rec.index = IDX_BITS'(k);
                  rec.supported = sup;
                  rec.last = (k == NUM_LIMBS - 1);
                  expected_limbs = {expected_limbs, rec};
               end
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_limbs.size() == 0) begin
               if (fail_count < 10)
                  $display("Unexpected response limb %h index %0d", rsp_ch.result_limb,
                           rsp_ch.result_index);
               fail_count <= fail_count + 1;
            end else begin
               rec = expected_limbs.pop_front();
               if (rec.limb !== rsp_ch.result_limb || rec.index !== rsp_ch.result_index ||
                   rec.supported !== rsp_ch.supported || rec.last !== rsp_ch.last) begin
                  if (fail_count < 10)
                     $display("Mismatch: expected limb %h idx %0d sup %b last %b, got %h %0d %b %b",
                              rec.limb, rec.index, rec.supported, rec.last,
                              rsp_ch.result_limb, rsp_ch.result_index, rsp_ch.supported,
                              rsp_ch.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// File: dv/tb_top.sv
// Testbench top for the EVM word ALU: clock, reset, request stimulus and verdict.
module tb_top;
   import ewa_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycle_count;
   int   sent_count;
   int   exp_budget;
   bit   no_idle;
   bit   hold_rsp;

   ewa_req_if req_ch ();
   ewa_rsp_if rsp_ch ();

   evm_word_alu u_top (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));

   ewa_scoreboard u_checker (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
                             .fail_count(fail_count), .pending(pending));

   localparam logic [7:0] KNOWN_OPS[25] = '{OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_SDIV, OP_MOD,
      OP_SMOD, OP_ADDMOD, OP_MULMOD, OP_EXP, OP_SIGNEXT, OP_LT, OP_GT, OP_SLT, OP_SGT, OP_EQ,
      OP_ISZERO, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_BYTE, OP_SHL, OP_SHR, OP_SAR};

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 3000000) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Response side: random back-pressure, or a long hold-off when asked for.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_ch.ready <= no_idle || ($urandom_range(99) >= 9);
      end
   end

   task automatic send_req(logic cmd, logic [7:0] opcode, logic [1:0] idx,
                           logic [63:0] a, logic [63:0] b, logic [63:0] c);
      if (!no_idle && $urandom_range(99) < 9) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.opcode <= opcode;
      req_ch.limb_index <= idx;
      req_ch.a_limb <= a;
      req_ch.b_limb <= b;
      req_ch.c_limb <= c;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   task automatic load_words(word_type a, word_type b, word_type c);
      for (int k = 0; k < NUM_LIMBS; k++)
         send_req(CMD_LOAD, 8'($urandom), 2'(k), a[k*64 +: 64], b[k*64 +: 64],
                  c[k*64 +: 64]);
   endtask

   task automatic run_op(logic [7:0] opcode);
      send_req(CMD_EXEC, opcode, 2'($urandom), 64'($urandom), 64'($urandom),
               64'($urandom));
   endtask

   function automatic word_type pick_word();
      word_type w;
      case ($urandom_range(7))
         0: w = '0;
         1: w = word_type'(1);
         2: w = '1;
         3: w = {1'b1, 255'd0};
         4: w = word_type'($urandom_range(300));
         5: w = -word_type'($urandom_range(300));
         default: w = {$urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom};
      endcase
      return w;
   endfunction

   initial begin
      logic [7:0] opcode;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_LOAD;
      req_ch.opcode = '0;
      req_ch.limb_index = '0;
      req_ch.a_limb = '0;
      req_ch.b_limb = '0;
      req_ch.c_limb = '0;
      no_idle = 1'b0;
      hold_rsp = 1'b0;
      sent_count = 0;
      exp_budget = 2;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: signed overflow, zero divisors, large shift and byte and sign positions, an unknown opcode and EXP.
      load_words({1'b1, 255'd0}, '1, '0);
      run_op(OP_SDIV);
      run_op(OP_ADDMOD);
      load_words(word_type'(256), '1, '1);
      run_op(OP_SAR);
      run_op(OP_SHL);
      load_words(word_type'(32), '0, '0);
      run_op(OP_BYTE);
      run_op(OP_DIV);
      run_op(OP_SMOD);
      load_words(word_type'(31), {1'b1, 255'd0}, '0);
      run_op(OP_SIGNEXT);
      run_op(OP_MULMOD);
      run_op(8'hff);
      load_words(word_type'(3), word_type'(5), word_type'(7));
      run_op(OP_EXP);

      while (sent_count < 200) begin
         if (sent_count > 60 && sent_count < 110) no_idle = 1'b1;
         else no_idle = 1'b0;
         if ($urandom_range(9) < 7) begin
            load_words(pick_word(), pick_word(), pick_word());
         end else begin
            repeat ($urandom_range(1, 3))
               send_req(CMD_LOAD, 8'($urandom), 2'($urandom), {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom});
         end
         if ($urandom_range(9) == 0) opcode = 8'($urandom);
         else opcode = KNOWN_OPS[$urandom_range(24)];
         if (opcode == OP_EXP) begin
            if (exp_budget > 0) exp_budget--;
            else opcode = OP_ADD;
         end
         run_op(opcode);
         if (sent_count > 130 && sent_count < 140) hold_rsp = 1'b1;
         if (sent_count > 160 && sent_count < 170) begin
            req_ch.valid <= 1'b0;
            wait (pending == 0);
            @(posedge clock);
         end
      end
      req_ch.valid <= 1'b0;

      wait (pending == 0);
      repeat (1000) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
